// ----- hw/rtl/flmw_pkg.sv -----
// ----------------------------------------------------------------------------
// flmw_pkg
// Types and fixed constants of the honest-weight accumulator.
// ----------------------------------------------------------------------------
package flmw_pkg;

  localparam int FRAC_W   = 16;
  localparam int SUM_W    = 27;
  localparam int WEIGHT_W = 17;
  localparam int LEAF_W   = 16;
  localparam int ROW_W    = 6;
  localparam int CFG_W    = 11;

  // build limits on the row counts
  localparam int MAX_TEST_ROWS   = 64;
  localparam int MAX_HONEST_ROWS = 64;

  localparam logic [2:0] MODE_LOAD  = 3'd0;
  localparam logic [2:0] MODE_TEST  = 3'd1;
  localparam logic [2:0] MODE_READ  = 3'd2;
  localparam logic [2:0] MODE_MEAN  = 3'd3;
  localparam logic [2:0] MODE_CLEAR = 3'd4;

  localparam logic [1:0] CFG_TREES  = 2'd0;
  localparam logic [1:0] CFG_TEST   = 2'd1;
  localparam logic [1:0] CFG_HONEST = 2'd2;

  typedef struct packed {
    logic [2:0]        mode;
    logic [ROW_W-1:0]  test_row;
    logic [ROW_W-1:0]  honest_row;
    logic [LEAF_W-1:0] leaf_id;
    logic [LEAF_W-1:0] leaf_count;
  } in_item_t;

  typedef struct packed {
    logic [WEIGHT_W-1:0] weight;
    logic                index_error;
  } out_item_t;

  // classified command passed from front to back
  typedef struct packed {
    logic [2:0]        mode;
    logic              bad;
    logic [ROW_W-1:0]  test_row;
    logic [ROW_W-1:0]  honest_row;
    logic [LEAF_W-1:0] leaf_id;
    logic [LEAF_W-1:0] leaf_count;
  } cmd_t;

endpackage

// ----- hw/rtl/flmw_ram.sv -----
// ----------------------------------------------------------------------------
// flmw_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module flmw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/flmw_front.sv -----
// ----------------------------------------------------------------------------
// flmw_front
// Accepts transactions, checks row indexes and queues classified commands.
// ----------------------------------------------------------------------------
module flmw_front import flmw_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_item_t   in_data,
  input  logic [6:0] ntest,
  input  logic [6:0] nhon,
  output logic       cmd_valid,
  input  logic       cmd_ready,
  output cmd_t       cmd_data
);

  localparam int QD = 2;

  cmd_t       q_r [QD];
  logic [0:0] wp_r, rp_r;
  logic [1:0] cnt_r;
  cmd_t       c;
  logic       push, pop;

  // classify: bad index per mode
  always_comb begin
    c.mode       = in_data.mode;
    c.test_row   = in_data.test_row;
    c.honest_row = in_data.honest_row;
    c.leaf_id    = in_data.leaf_id;
    c.leaf_count = in_data.leaf_count;
    case (in_data.mode)
      MODE_LOAD: c.bad = {1'b0, in_data.honest_row} >= nhon;
      MODE_TEST: c.bad = {1'b0, in_data.test_row} >= ntest;
      MODE_READ: c.bad = ({1'b0, in_data.test_row} >= ntest) ||
                         ({1'b0, in_data.honest_row} >= nhon);
      MODE_MEAN: c.bad = {1'b0, in_data.honest_row} >= nhon;
      default:   c.bad = 1'b0;
    endcase
  end

  assign in_ready  = cnt_r != 2'(QD);
  assign push      = in_valid && in_ready;
  assign cmd_valid = cnt_r != 2'd0;
  assign pop       = cmd_valid && cmd_ready;
  assign cmd_data  = q_r[rp_r];

  // command queue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        q_r[wp_r] <= c;
        wp_r      <= wp_r + 1'b1;
      end
      if (pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

endmodule

// ----- hw/rtl/flmw_div.sv -----
// ----------------------------------------------------------------------------
// flmw_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module flmw_div #(
  parameter int NW = 33,
  parameter int DW = 18
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quo
);

  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] q_r;
  logic [DW:0]   rem_r;
  logic [DW-1:0] d_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r, done_r;
  logic [DW:0]   trial;

  assign trial = {rem_r[DW-1:0], q_r[NW-1]};
  assign done  = done_r;
  assign quo   = q_r;

  // shift-subtract iteration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        q_r    <= num;
        d_r    <= den;
        rem_r  <= '0;
        cnt_r  <= CW'(NW);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (trial >= {1'b0, d_r}) begin
          rem_r <= trial - {1'b0, d_r};
          q_r   <= {q_r[NW-2:0], 1'b1};
        end else begin
          rem_r <= trial;
          q_r   <= {q_r[NW-2:0], 1'b0};
        end
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- hw/rtl/flmw_back.sv -----
// ----------------------------------------------------------------------------
// flmw_back
// Executes commands: honest loads, test walks, reads, means and clears.
// ----------------------------------------------------------------------------
module flmw_back import flmw_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cmd_valid,
  output logic        cmd_ready,
  input  cmd_t        cmd_data,
  input  logic [6:0]  ntest,
  input  logic [6:0]  nhon,
  input  logic [10:0] ntrees,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data
);

  localparam int HD = 64;
  localparam int SD = 4096;
  localparam int RECIP_W = 17;
  localparam int NUM_W = SUM_W + 6;
  localparam int DEN_W = 18;
  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
  localparam logic [NUM_W-1:0] W_MAX = NUM_W'({WEIGHT_W{1'b1}});

  typedef enum logic [3:0] {
    S_IDLE, S_DIV0, S_CLR, S_WALK, S_RD, S_RDW, S_DIV, S_DIVW, S_OUT
  } state_t;

  state_t           st_r;
  cmd_t             c_r;
  logic [12:0]      idx_r;        // walk / clear / column index (with end bit)
  logic [6:0]       lat_r;        // rows issued, pipelined read-back
  logic             p1_v_r;
  logic [5:0]       p1_j_r;
  logic [NUM_W-1:0] tot_r;
  logic [NUM_W-1:0] num_r;
  logic [DEN_W-1:0] den_r;
  logic             dstart_r;
  out_item_t        res_r;
  logic             ov_r;

  // honest tables
  logic             h_we;
  logic [5:0]       h_waddr, h_raddr;
  logic [LEAF_W-1:0]  hl_rd;
  logic [RECIP_W-1:0] hr_rd, recip;

  // sum memory
  logic             s_we;
  logic [11:0]      s_waddr, s_raddr;
  logic [SUM_W-1:0] s_wdata, s_rd;

  logic             d_done;
  logic [NUM_W-1:0] d_quo;

  // zero leaf size stores a zero reciprocal
  assign recip = (c_r.leaf_count == '0) ? '0 : d_quo[RECIP_W-1:0];

  flmw_ram #(.WIDTH(LEAF_W), .DEPTH(HD)) u_hleaf (
    .clk(clk), .we(h_we), .waddr(h_waddr), .wdata(c_r.leaf_id),
    .raddr(h_raddr), .rdata(hl_rd));
  flmw_ram #(.WIDTH(RECIP_W), .DEPTH(HD)) u_hrecip (
    .clk(clk), .we(h_we), .waddr(h_waddr), .wdata(recip),
    .raddr(h_raddr), .rdata(hr_rd));
  flmw_ram #(.WIDTH(SUM_W), .DEPTH(SD)) u_sums (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .raddr(s_raddr), .rdata(s_rd));

  flmw_div #(.NW(NUM_W), .DW(DEN_W)) u_div (
    .clk(clk), .rst_n(rst_n), .start(dstart_r), .num(num_r), .den(den_r),
    .done(d_done), .quo(d_quo));

  assign cmd_ready = (st_r == S_IDLE) && !ov_r;
  assign out_valid = ov_r;
  assign out_data  = res_r;

  // read address: walk row, read cell or column cell
  always_comb begin
    h_raddr = idx_r[5:0];
    case (st_r)
      S_WALK:  s_raddr = {c_r.test_row, idx_r[5:0]};
      S_RD:    s_raddr = (c_r.mode == MODE_READ) ? {c_r.test_row, c_r.honest_row} :
                                                   {idx_r[5:0], c_r.honest_row};
      default: s_raddr = {c_r.test_row, c_r.honest_row};
    endcase
  end

  // write ports
  always_comb begin
    h_we    = (st_r == S_DIV0) && ((c_r.leaf_count == '0) || d_done);
    h_waddr = c_r.honest_row;
    s_we    = 1'b0;
    s_waddr = {c_r.test_row, p1_j_r};
    s_wdata = '0;
    if (st_r == S_CLR) begin
      s_we    = 1'b1;
      s_waddr = idx_r[11:0];
    end else if (p1_v_r && (hl_rd == c_r.leaf_id)) begin
      s_we    = 1'b1;
      s_wdata = ({1'b0, s_rd} + (SUM_W+1)'(hr_rd)) > {1'b0, SUM_MAX} ? SUM_MAX :
                s_rd + SUM_W'(hr_rd);
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= S_CLR;
      idx_r    <= '0;
      ov_r     <= 1'b0;
      p1_v_r   <= 1'b0;
      dstart_r <= 1'b0;
    end else begin
      dstart_r <= 1'b0;
      p1_v_r   <= 1'b0;
      if (ov_r && out_ready) ov_r <= 1'b0;
      case (st_r)
        S_IDLE: begin
          if (cmd_valid && !ov_r) begin
            c_r   <= cmd_data;
            idx_r <= '0;
            tot_r <= '0;
            lat_r <= '0;
            if (cmd_data.bad && (cmd_data.mode <= MODE_MEAN)) begin
              res_r <= '{weight: '0, index_error: 1'b1};
              ov_r  <= 1'b1;
            end else begin
              case (cmd_data.mode)
                MODE_LOAD: begin
                  num_r    <= NUM_W'(1) << FRAC_W;
                  den_r    <= DEN_W'(cmd_data.leaf_count);
                  dstart_r <= cmd_data.leaf_count != '0;
                  st_r     <= S_DIV0;
                end
                MODE_TEST:  st_r <= S_WALK;
                MODE_READ:  st_r <= S_RD;
                MODE_MEAN:  begin
                  if (ntest == '0) begin
                    res_r <= '{weight: '0, index_error: 1'b0};
                    ov_r  <= 1'b1;
                  end else st_r <= S_RD;
                end
                MODE_CLEAR: st_r <= S_CLR;
                default:    st_r <= S_IDLE;
              endcase
            end
          end
        end
        S_DIV0: begin
          // zero leaf size stores zero without running the divider
          if (c_r.leaf_count == '0 || d_done) st_r <= S_IDLE;
        end
        S_CLR: begin
          idx_r <= idx_r + 1'b1;
          if (idx_r[11:0] == 12'(SD - 1)) st_r <= S_IDLE;
        end
        S_WALK: begin
          // issue one read per cycle; write back in the cycle after each read
          if (idx_r[6:0] < nhon) begin
            p1_v_r <= 1'b1;
            p1_j_r <= idx_r[5:0];
            idx_r  <= idx_r + 1'b1;
          end else if (!p1_v_r) begin
            st_r <= S_IDLE;
          end
        end
        S_RD: begin
          // mode 2 reads one cell; mode 3 sums a column over test rows
          if (c_r.mode == MODE_READ) begin
            lat_r <= lat_r + 1'b1;
            if (lat_r == 7'd1) begin
              num_r <= NUM_W'(s_rd);
              den_r <= (ntrees == '0) ? DEN_W'(1) : DEN_W'(ntrees);
              dstart_r <= 1'b1;
              st_r  <= S_DIVW;
            end
          end else begin
            if (idx_r[6:0] < ntest) idx_r <= idx_r + 1'b1;
            lat_r <= lat_r + 1'b1;
            if (lat_r >= 7'd1) tot_r <= tot_r + NUM_W'(s_rd);
            if (lat_r == ntest) st_r <= S_DIV;
          end
        end
        S_DIV: begin
          num_r    <= tot_r;
          den_r    <= DEN_W'(ntrees == '0 ? 11'd1 : ntrees) * DEN_W'(ntest);
          dstart_r <= 1'b1;
          st_r     <= S_DIVW;
        end
        S_DIVW: begin
          if (d_done) begin
            res_r.weight      <= (d_quo > W_MAX) ? WEIGHT_W'(W_MAX) :
                                 d_quo[WEIGHT_W-1:0];
            res_r.index_error <= 1'b0;
            ov_r <= 1'b1;
            st_r <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- hw/rtl/forest_leaf_match_weights_top.sv -----
// ----------------------------------------------------------------------------
// forest_leaf_match_weights_top
// Honest random-forest weight accumulator with 16 fraction bits.
// ----------------------------------------------------------------------------
// in_* carries one command transaction (mode, rows, leaf id, leaf size);
// out_* returns at most one result (weight, index_error) per transaction.
// cfg_* writes tree count, test row count and honest row count.
// A two-entry queue separates classification from execution.
// Work per transaction, done by the sequencer and its divider:
//   load honest: a one-bit-per-cycle reciprocal division, skipped for a
//   zero leaf size (a zero reciprocal is stored)
//   test entry: one sum read-modify-write a cycle over the honest rows
//   read weight: cell / trees; column mean: column sum / (trees * test rows)
//   clear: all 4096 sum entries, one sum entry per cycle
// After reset a pass clears all 4096 sum entries, during which
// no transaction is executed (they queue). A stalled receiver holds the
// result register; the back end then waits, and the queue fills.
// ----------------------------------------------------------------------------
module forest_leaf_match_weights_top import flmw_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_data,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  logic [10:0] ntrees_r;
  logic [6:0]  ntest_r, nhon_r, ntest, nhon;
  logic        cmd_valid, cmd_ready;
  cmd_t        cmd_data;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ntrees_r <= 11'd1;
      ntest_r  <= 7'd64;
      nhon_r   <= 7'd64;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TREES:  ntrees_r <= cfg_data;
        CFG_TEST:   ntest_r  <= cfg_data[6:0];
        CFG_HONEST: nhon_r   <= cfg_data[6:0];
        default:    ;
      endcase
    end
  end

  // clamp row counts to the build limits
  assign ntest = (ntest_r > 7'(MAX_TEST_ROWS)) ? 7'(MAX_TEST_ROWS) : ntest_r;
  assign nhon  = (nhon_r > 7'(MAX_HONEST_ROWS)) ? 7'(MAX_HONEST_ROWS) : nhon_r;

  flmw_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .ntest(ntest), .nhon(nhon),
    .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd_data(cmd_data));

  flmw_back u_back (
    .clk(clk), .rst_n(rst_n), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready),
    .cmd_data(cmd_data), .ntest(ntest), .nhon(nhon), .ntrees(ntrees_r),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data));

endmodule
